// ===== sv/ulist_pkg.sv =====
// Types and codes for the unordered item list table.
// No dependencies; imported by unordered_item_list_table_top.
package ulist_pkg;

  localparam int unsigned ITEM_WIDTH   = 32;
  localparam int unsigned ITEM_COUNT_W = 5;

  typedef enum logic [2:0] {
    ACT_PUT    = 3'd0,
    ACT_FIND   = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_RESET  = 3'd3,
    ACT_NEXT   = 3'd4,
    ACT_EMPTY  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_SHIFT = 2'd2,
    S_FETCH = 2'd3
  } state_e;

  typedef struct packed {
    logic [2:0]            action;
    logic [ITEM_WIDTH-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [ITEM_WIDTH-1:0]   item_out;
    logic                    found;
    logic [1:0]              status;
    logic [ITEM_COUNT_W-1:0] item_count;
  } res_t;

endpackage

// ===== sv/unordered_item_list_table_top.sv =====
// Bounded unordered list of items, newest first, kept in one synchronous RAM.
// Depends on ulist_pkg (request/result structs, action, status and state codes).
//
//  channel  | handshake           | payload | beat taken when
//  ---------+---------------------+---------+------------------------------
//  request  | start, busy         | req_i   | start high while busy low
//  result   | valid_o             | res_o   | every cycle valid_o is high
//
// Put, reset cursor, make empty and unused codes are done in the accepting state;
// next on a non-empty list adds one RAM read (S_FETCH). Find walks the RAM from the
// head, one entry a cycle; delete adds a shift pass that moves each entry behind the
// match down one slot, one read and one write per entry, then drains the last write.
// The single RAM port pair (one read, one write per cycle) sets this pace.
// Reset clears count, cursor and the FSM; the RAM holds no reset state, since
// only slots below count are ever read. The result is registered and shown for
// one cycle; the receiver cannot stall, so busy depends on the FSM alone and a
// new beat may start in the cycle its predecessor's result is shown.
module unordered_item_list_table_top
  import ulist_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic valid_o,
  output res_t res_o
);

  // count holds 0..CAPACITY, slot addresses 0..CAPACITY-1
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  // Entry RAM: slot count-1 is the head, slot 0 the tail.
  logic [ITEM_WIDTH-1:0] mem [CAPACITY];
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [ITEM_WIDTH-1:0] mem_wd;
  logic                  mem_re;
  logic [AW-1:0]         mem_ra;
  logic [ITEM_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  // Control state
  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cursor_q, cursor_d;
  logic          pend_q, pend_d;      // a read issued last cycle returns now
  logic          valid_q, valid_d;

  // Working registers of the current beat (payload, no reset)
  logic [2:0]            op_q, op_d;
  logic [ITEM_WIDTH-1:0] val_q, val_d;
  logic [CW-1:0]         left_q, left_d;  // entries still to read in a scan
  logic [CW-1:0]         sh_q, sh_d;      // next slot to read in the shift pass
  logic [AW-1:0]         apipe_q, apipe_d; // slot tied to the read in flight
  res_t                  res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      pend_q   <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      pend_q   <= pend_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    val_q   <= val_d;
    left_q  <= left_d;
    sh_q    <= sh_d;
    apipe_q <= apipe_d;
    res_q   <= res_d;
  end

  // Shared conditions
  logic          accept;
  logic          full;
  logic          hit;
  logic          scan_miss;
  logic          shift_more;
  logic          shift_done;
  logic [CW-1:0] left_dec;
  logic [CW-1:0] cur_new;
  logic [CW-1:0] fetch_slot;

  assign busy       = (state_q != S_IDLE);
  assign accept     = start && !busy;
  assign full       = (count_q >= CW'(CAPACITY));
  assign hit        = pend_q && (rdata_q == val_q);
  assign scan_miss  = !hit && (left_q == '0);
  assign shift_more = (sh_q < count_q);
  assign shift_done = !shift_more && !pend_q;
  assign left_dec   = left_q - CW'(1);
  // Wrap to the head from before the head, the tail, or beyond the count
  assign cur_new    = ((cursor_q == '0) || (cursor_q >= count_q)) ? CW'(1)
                                                                  : cursor_q + CW'(1);
  assign fetch_slot = count_q - cur_new;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((req_i.action == ACT_FIND) || (req_i.action == ACT_DELETE)) begin
            state_d = S_SCAN;
          end else if ((req_i.action == ACT_NEXT) && (count_q != '0)) begin
            state_d = S_FETCH;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = (op_q == ACT_DELETE) ? S_SHIFT : S_IDLE;
        end else if (scan_miss) begin
          state_d = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (shift_done) begin
          state_d = S_IDLE;
        end
      end
      S_FETCH: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, RAM control and result
  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    pend_d   = 1'b0;
    valid_d  = 1'b0;
    op_d     = op_q;
    val_d    = val_q;
    left_d   = left_q;
    sh_d     = sh_q;
    apipe_d  = apipe_q;
    res_d    = res_q;
    mem_we   = 1'b0;
    mem_wa   = apipe_q;
    mem_wd   = rdata_q;
    mem_re   = 1'b0;
    mem_ra   = apipe_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = req_i.action;
          val_d = req_i.item_value;
          res_d = '0;
          unique case (req_i.action) inside
            ACT_PUT: begin
              cursor_d = '0;
              valid_d  = 1'b1;
              if (full) begin
                res_d.status = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                mem_wa  = count_q[AW-1:0];
                mem_wd  = req_i.item_value;
                count_d = count_q + CW'(1);
              end
            end
            ACT_FIND, ACT_DELETE: begin
              left_d = count_q;
            end
            ACT_RESET: begin
              cursor_d = '0;
              valid_d  = 1'b1;
            end
            ACT_NEXT: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
                valid_d      = 1'b1;
              end else begin
                cursor_d = cur_new;
                mem_re   = 1'b1;
                mem_ra   = fetch_slot[AW-1:0];
              end
            end
            ACT_EMPTY: begin
              count_d  = '0;
              cursor_d = '0;
              valid_d  = 1'b1;
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          if (op_q == ACT_DELETE) begin
            // Close the gap: pull every newer entry down one slot
            cursor_d = '0;
            sh_d     = CW'(apipe_q) + CW'(1);
          end else begin
            res_d.item_out = rdata_q;
            res_d.found    = 1'b1;
            valid_d        = 1'b1;
          end
        end else if (scan_miss) begin
          if (op_q == ACT_DELETE) begin
            cursor_d = '0;
          end
          res_d.status = ST_NOT_FOUND;
          valid_d      = 1'b1;
        end else begin
          // Advance toward the tail, one read per cycle
          mem_re  = 1'b1;
          mem_ra  = left_dec[AW-1:0];
          apipe_d = left_dec[AW-1:0];
          left_d  = left_dec;
          pend_d  = 1'b1;
        end
      end

      S_SHIFT: begin
        if (pend_q) begin
          mem_we = 1'b1;
          mem_wa = apipe_q;
          mem_wd = rdata_q;
        end
        if (shift_more) begin
          mem_re  = 1'b1;
          mem_ra  = sh_q[AW-1:0];
          apipe_d = sh_q[AW-1:0] - AW'(1);
          sh_d    = sh_q + CW'(1);
          pend_d  = 1'b1;
        end else if (!pend_q) begin
          count_d     = count_q - CW'(1);
          res_d.found = 1'b1;
          valid_d     = 1'b1;
        end
      end

      S_FETCH: begin
        res_d.item_out = rdata_q;
        valid_d        = 1'b1;
      end

      default: ;
    endcase

    if (valid_d) begin
      res_d.item_count = ITEM_COUNT_W'(count_d);
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for unordered_item_list_table_top: a directed command table, then random
// command beats, all scored against a behavioral list model kept in this module.
// Depends on ulist_pkg (req_t, res_t, action and status codes) and the DUT top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ulist_pkg::*;

  localparam int unsigned LIST_DEPTH    = 16;
  localparam int unsigned RAND_BEATS    = 1400;
  localparam int unsigned POOL_SIZE     = 6;
  // A delete of the tail walks and shifts the whole list before it settles.
  localparam int unsigned SETTLE_CYCLES = 2 * LIST_DEPTH + 8;
  localparam int unsigned DRAIN_LIMIT   = 2000;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_REPORTS   = 10;

  // Action codes the block must ignore.
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  localparam logic [ITEM_WIDTH-1:0] ALL_ONES = '1;

  typedef struct {
    logic [2:0]            act;
    logic [ITEM_WIDTH-1:0] val;
    int                    reps;
    bit                    typed;
    res_t                  want;
  } dir_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic valid;
  res_t res;

  // Shadow list, newest entry in slot list_count-1.
  logic [ITEM_WIDTH-1:0] list_slots [LIST_DEPTH];
  int                    list_count  = 0;
  int                    list_cursor = 0;

  res_t                  awaited_results [$];
  logic [ITEM_WIDTH-1:0] value_pool [POOL_SIZE];
  int                    idle_pct    = 7;
  int                    fail_cnt    = 0;
  int                    checked_cnt = 0;
  int                    action_tally [8];
  int                    hit_tally   = 0;
  int                    full_tally  = 0;
  int                    empty_tally = 0;
  int unsigned           cycle_cnt   = 0;

  unordered_item_list_table_top #(
    .CAPACITY (LIST_DEPTH)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .start   (start),
    .busy    (busy),
    .req_i   (req),
    .valid_o (valid),
    .res_o   (res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop: no correct run comes near this.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void log_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Apply one command to the shadow list and return the result it must produce.
  function automatic res_t apply_list_action(input req_t r);
    res_t o;
    int   hit;
    o   = '0;
    hit = -1;
    action_tally[r.action]++;
    // Find and delete both take the first match counted from the head.
    if (r.action == ACT_FIND || r.action == ACT_DELETE) begin
      for (int k = 0; k < list_count; k++) begin
        if (hit < 0 && list_slots[list_count-1-k] == r.item_value) hit = list_count - 1 - k;
      end
    end
    case (r.action)
      ACT_PUT: begin
        if (list_count >= LIST_DEPTH) begin
          o.status = ST_FULL;
          full_tally++;
        end else begin
          list_slots[list_count] = r.item_value;
          list_count++;
        end
        list_cursor = 0;
      end
      ACT_FIND: begin
        if (hit >= 0) begin
          o.found    = 1'b1;
          o.item_out = list_slots[hit];
          hit_tally++;
        end else begin
          o.status = ST_NOT_FOUND;
        end
      end
      ACT_DELETE: begin
        if (hit >= 0) begin
          // Close the gap: everything nearer the head moves down one slot.
          for (int i = hit; i + 1 < list_count; i++) list_slots[i] = list_slots[i+1];
          list_count--;
          o.found = 1'b1;
          hit_tally++;
        end else begin
          o.status = ST_NOT_FOUND;
        end
        list_cursor = 0;
      end
      ACT_RESET: begin
        list_cursor = 0;
      end
      ACT_NEXT: begin
        if (list_count == 0) begin
          o.status = ST_EMPTY;
          empty_tally++;
        end else begin
          // Wrap to the head from before-head, the tail, or anything past the count.
          if (list_cursor == 0 || list_cursor >= list_count) list_cursor = 1;
          else list_cursor++;
          o.item_out = list_slots[list_count-list_cursor];
        end
      end
      ACT_EMPTY: begin
        list_count  = 0;
        list_cursor = 0;
      end
      default: begin
      end
    endcase
    o.item_count = ITEM_COUNT_W'(list_count);
    return o;
  endfunction

  // Random command, biased so the list fills up, hits its limit and sees real matches.
  function automatic req_t pick_request();
    req_t r;
    int   roll;
    roll = $urandom_range(99);
    if (roll < ((list_count < LIST_DEPTH) ? 55 : 25)) begin
      r.action = ACT_PUT;
    end else begin
      roll = $urandom_range(99);
      if (roll < 30) r.action = ACT_FIND;
      else if (roll < 55) r.action = ACT_DELETE;
      else if (roll < 80) r.action = ACT_NEXT;
      else if (roll < 88) r.action = ACT_RESET;
      else if (roll < 92) r.action = ACT_EMPTY;
      else if (roll < 96) r.action = ACT_SPARE6;
      else r.action = ACT_SPARE7;
    end
    // Mostly pool values so duplicates and hits are common; some extremes and raw noise.
    roll = $urandom_range(99);
    if (roll < 70) r.item_value = value_pool[$urandom_range(POOL_SIZE-1)];
    else if (roll < 75) r.item_value = '0;
    else if (roll < 80) r.item_value = ALL_ONES;
    else r.item_value = $urandom();
    return r;
  endfunction

  function automatic dir_row_t mk_row(input logic [2:0] act, input logic [ITEM_WIDTH-1:0] val,
                                      input int reps, input bit typed,
                                      input logic [ITEM_WIDTH-1:0] item, input logic found,
                                      input status_e status, input int cnt);
    dir_row_t row;
    row.act   = act;
    row.val   = val;
    row.reps  = reps;
    row.typed = typed;
    row.want  = '{item_out: item, found: found, status: status,
                  item_count: ITEM_COUNT_W'(cnt)};
    return row;
  endfunction

  // Offer one beat; all calls start and end at a rising edge. Busy only moves at
  // edges, so the value seen at the falling edge is what the next edge samples.
  task automatic send_beat(input req_t item, input bit typed, input res_t typed_res);
    res_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= item;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    // Beat taken at this edge: advance the shadow list and queue what must come back.
    predicted = apply_list_action(item);
    awaited_results.push_back(typed ? typed_res : predicted);
  endtask

  // Hold off until every queued result has come back, then let the block settle.
  task automatic drain_results();
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Results are registered and held for one cycle; sample mid-cycle so the
  // check never races the edge that moves them.
  always @(negedge clk) begin : result_check
    res_t want;
    if (rst_n && valid !== 1'b0) begin
      if (awaited_results.size() == 0) begin
        log_failure($sformatf("result with nothing pending: %p", res));
      end else begin
        want = awaited_results.pop_front();
        if (res.item_out !== want.item_out || res.found !== want.found ||
            res.status !== want.status || res.item_count !== want.item_count) begin
          log_failure($sformatf(
            "result %0d: item_out %h/%h found %b/%b status %0d/%0d count %0d/%0d (want/got)",
            checked_cnt, want.item_out, res.item_out, want.found, res.found,
            want.status, res.status, want.item_count, res.item_count));
        end
        checked_cnt++;
      end
    end
  end

  initial begin : stimulus
    dir_row_t rows [$];
    req_t     item;

    // Directed table. Typed results only where they are obvious: empty-list
    // reads, misses, ignored codes, the full rejection and plain counts.
    rows.push_back(mk_row(ACT_NEXT,   '0,            1, 1'b1, '0, 1'b0, ST_EMPTY, 0));
    rows.push_back(mk_row(ACT_FIND,   '0,            1, 1'b1, '0, 1'b0, ST_NOT_FOUND, 0));
    rows.push_back(mk_row(ACT_DELETE, ALL_ONES,      1, 1'b1, '0, 1'b0, ST_NOT_FOUND, 0));
    rows.push_back(mk_row(ACT_PUT,    '0,            1, 1'b1, '0, 1'b0, ST_OK, 1));
    rows.push_back(mk_row(ACT_PUT,    ALL_ONES,      1, 1'b1, '0, 1'b0, ST_OK, 2));
    rows.push_back(mk_row(ACT_PUT,    32'hA5A5_5A5A, 1, 1'b0, '0, 1'b0, ST_OK, 0));
    // Duplicate of the tail value, so the head copy must win below.
    rows.push_back(mk_row(ACT_PUT,    '0,            1, 1'b0, '0, 1'b0, ST_OK, 0));
    rows.push_back(mk_row(ACT_FIND,   ALL_ONES,      1, 1'b1, ALL_ONES, 1'b1, ST_OK, 4));
    // Walk all four entries and wrap back to the head.
    rows.push_back(mk_row(ACT_NEXT,   '0,            5, 1'b0, '0, 1'b0, ST_OK, 0));
    rows.push_back(mk_row(ACT_RESET,  ALL_ONES,      1, 1'b1, '0, 1'b0, ST_OK, 4));
    rows.push_back(mk_row(ACT_NEXT,   '0,            1, 1'b0, '0, 1'b0, ST_OK, 0));
    rows.push_back(mk_row(ACT_SPARE6, ALL_ONES,      1, 1'b1, '0, 1'b0, ST_OK, 4));
    rows.push_back(mk_row(ACT_SPARE7, 32'h5A5A_A5A5, 1, 1'b1, '0, 1'b0, ST_OK, 4));
    rows.push_back(mk_row(ACT_DELETE, '0,            1, 1'b0, '0, 1'b0, ST_OK, 0));
    rows.push_back(mk_row(ACT_NEXT,   '0,            2, 1'b0, '0, 1'b0, ST_OK, 0));
    rows.push_back(mk_row(ACT_FIND,   '0,            1, 1'b0, '0, 1'b0, ST_OK, 0));
    rows.push_back(mk_row(ACT_DELETE, 32'h1234_5678, 1, 1'b1, '0, 1'b0, ST_NOT_FOUND, 3));
    rows.push_back(mk_row(ACT_EMPTY,  ALL_ONES,      1, 1'b1, '0, 1'b0, ST_OK, 0));
    // Fill to the limit with distinct values, then one more put must bounce.
    rows.push_back(mk_row(ACT_PUT,    32'h100,      16, 1'b0, '0, 1'b0, ST_OK, 0));
    rows.push_back(mk_row(ACT_PUT,    32'hDEAD,      1, 1'b1, '0, 1'b0, ST_FULL, 16));
    rows.push_back(mk_row(ACT_NEXT,   '0,            1, 1'b0, '0, 1'b0, ST_OK, 0));
    // Deleting the tail forces the longest walk and shift.
    rows.push_back(mk_row(ACT_DELETE, 32'h100,       1, 1'b0, '0, 1'b0, ST_OK, 0));
    rows.push_back(mk_row(ACT_FIND,   32'h10F,       1, 1'b0, '0, 1'b0, ST_OK, 0));
    rows.push_back(mk_row(ACT_FIND,   32'h100,       1, 1'b1, '0, 1'b0, ST_NOT_FOUND, 15));
    rows.push_back(mk_row(ACT_EMPTY,  '0,            1, 1'b1, '0, 1'b0, ST_OK, 0));

    foreach (action_tally[a]) action_tally[a] = 0;

    // Single reset at the start of the run.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      for (int k = 0; k < rows[i].reps; k++) begin
        item.action     = rows[i].act;
        item.item_value = rows[i].val + k;
        send_beat(item, rows[i].typed, rows[i].want);
      end
    end
    drain_results();

    // Random phases: light sender gaps, heavy gaps, then back-to-back beats.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 7 : (ph == 1) ? 59 : 0;
      foreach (value_pool[j]) value_pool[j] = $urandom();
      for (int n = 0; n < RAND_BEATS / 3; n++) begin
        // Now and then drop start and let the block run dry mid-phase.
        if ($urandom_range(199) == 0) drain_results();
        send_beat(pick_request(), 1'b0, '0);
      end
      drain_results();
    end

    if (awaited_results.size() != 0) begin
      log_failure($sformatf("%0d results never arrived", awaited_results.size()));
    end

    $display("Ran %0d beats: put %0d, find %0d, delete %0d, next %0d, cursor reset %0d, clear %0d.",
             checked_cnt, action_tally[ACT_PUT], action_tally[ACT_FIND],
             action_tally[ACT_DELETE], action_tally[ACT_NEXT], action_tally[ACT_RESET],
             action_tally[ACT_EMPTY]);
    $display("Saw %0d matches, %0d full rejections, %0d empty-list reads, %0d ignored codes.",
             hit_tally, full_tally, empty_tally,
             action_tally[ACT_SPARE6] + action_tally[ACT_SPARE7]);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ulist_pkg.sv
sv/unordered_item_list_table_top.sv
tb/tb_top.sv
